[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL files of the radix converter.
// No dependencies; define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);
// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);
`else
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[hw/rtl/u2a_pkg.sv]
// Package for the unsigned-to-ASCII radix converter: constants, state type
// and the digit-to-character function. No dependencies.
package u2a_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int OP_W = 2;
	localparam int FIELD_W = 32;
	localparam int CHAR_W = 7;
	localparam int DIGIT_W = 4;
	localparam int STORE_DEPTH = 10;

	// floor(x / 10) == (x * RECIP_MULT) >> RECIP_SHIFT for every x below 2**32
	localparam logic [31:0] RECIP_MULT = 32'hCCCC_CCCD;
	localparam int RECIP_SHIFT = 35;
	localparam int RADIX_DEC = 10;

	localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'd48;
	localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 7'd97;
	localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 7'd65;

	typedef enum logic [1:0] {
		IDLE,
		MUL,
		SPLIT,
		EMIT
	} u2a_state_t;

	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d,
			input logic upper);
		logic [CHAR_W-1:0] base;
		base = upper ? ASCII_UPPER_A : ASCII_LOWER_A;
		if (d < DIGIT_W'(RADIX_DEC)) begin
			return ASCII_ZERO + CHAR_W'(d);
		end else begin
			return base + CHAR_W'(d) - CHAR_W'(RADIX_DEC);
		end
	endfunction

endpackage

[hw/rtl/u2a_if.sv]
// Valid/ready channels of the radix converter: number in, characters out.
// Depends on u2a_pkg for the field widths.
interface u2a_in_if;
	logic valid;
	logic ready;
	logic [u2a_pkg::OP_W-1:0] operation;
	logic [u2a_pkg::FIELD_W-1:0] value;
	modport source (output valid, output operation, output value, input ready);
	modport sink (input valid, input operation, input value, output ready);
endinterface

interface u2a_out_if;
	logic valid;
	logic ready;
	logic [u2a_pkg::CHAR_W-1:0] character;
	logic last;
	modport source (output valid, output character, output last, input ready);
	modport sink (input valid, input character, input last, output ready);
endinterface

[hw/rtl/unsigned_to_ascii_radix.sv]
// Unsigned binary to ASCII decimal / hex converter, top level.
// Depends on u2a_pkg, u2a_if.sv and assert_macros.svh.
// The block accepts a number, then per digit does a reciprocal multiply and then quotient and
// remainder in decimal, or a shift in hex, then emits one character per cycle while chars.ready is high.
// One number at a time; reset clears sequencer and counters, not the digit store.
`include "assert_macros.svh"

module unsigned_to_ascii_radix #(
	parameter int VALUE_BITS = u2a_pkg::VALUE_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	u2a_in_if.sink number,
	u2a_out_if.source chars
);

	localparam int W = (VALUE_BITS < u2a_pkg::FIELD_W) ? VALUE_BITS : u2a_pkg::FIELD_W;
	localparam int PROD_W = W + 32;
	localparam int DEPTH = u2a_pkg::STORE_DEPTH;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int DW = u2a_pkg::DIGIT_W;

	u2a_pkg::u2a_state_t state_q, state_d;

	logic [W-1:0] rem_q;
	logic [PROD_W-1:0] prod_q;
	logic hex_q;
	logic upper_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] idx_q;
	logic [DW-1:0] digits_q [DEPTH];

	logic [W-1:0] dec_quot;
	logic [W-1:0] dec_ten;
	logic [DW-1:0] dec_digit;
	logic [W-1:0] quot_d;
	logic [DW-1:0] digit_d;
	logic split_done;
	logic in_fire;
	logic out_fire;

	// Quotient and remainder from the registered reciprocal product in decimal, by a shift in hex
	assign dec_quot = W'(prod_q >> u2a_pkg::RECIP_SHIFT);
	assign dec_ten = W'({dec_quot, 3'b000}) + W'({dec_quot, 1'b0});
	assign dec_digit = DW'(rem_q - dec_ten);
	assign quot_d = hex_q ? (rem_q >> DW) : dec_quot;
	assign digit_d = hex_q ? rem_q[DW-1:0] : dec_digit;
	assign split_done = (quot_d == '0) || (cnt_q == CNT_W'(DEPTH - 1));

	assign in_fire = number.valid && number.ready;
	assign out_fire = chars.valid && chars.ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			u2a_pkg::IDLE: begin
				if (number.valid) begin
					state_d = (number.operation != '0) ? u2a_pkg::SPLIT : u2a_pkg::MUL;
				end
			end
			u2a_pkg::MUL: begin
				state_d = u2a_pkg::SPLIT;
			end
			u2a_pkg::SPLIT: begin
				if (split_done) begin
					state_d = u2a_pkg::EMIT;
				end else begin
					state_d = hex_q ? u2a_pkg::SPLIT : u2a_pkg::MUL;
				end
			end
			u2a_pkg::EMIT: begin
				if (chars.ready && idx_q == '0) begin
					state_d = u2a_pkg::IDLE;
				end
			end
			default: begin
				state_d = u2a_pkg::IDLE;
			end
		endcase
	end

	always_comb begin
		number.ready = (state_q == u2a_pkg::IDLE);
		chars.valid = (state_q == u2a_pkg::EMIT);
		chars.character = u2a_pkg::digit_to_ascii(digits_q[idx_q], upper_q);
		chars.last = (idx_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= u2a_pkg::IDLE;
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (in_fire) begin
				cnt_q <= '0;
			end else if (state_q == u2a_pkg::SPLIT) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (split_done) begin
					// top digit sits at the slot just written
					idx_q <= cnt_q[IDX_W-1:0];
				end
			end else if (out_fire && idx_q != '0) begin
				idx_q <= idx_q - IDX_W'(1);
			end
		end
	end

	// Datapath: no reset needed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			rem_q <= number.value[W-1:0];
			hex_q <= (number.operation != '0);
			upper_q <= number.operation[1];
		end else if (state_q == u2a_pkg::MUL) begin
			prod_q <= PROD_W'(rem_q) * PROD_W'(u2a_pkg::RECIP_MULT);
		end else if (state_q == u2a_pkg::SPLIT) begin
			rem_q <= quot_d;
			digits_q[cnt_q[IDX_W-1:0]] <= digit_d;
		end
	end

	`ASSERT_SAME(a_one_side, clk, arst_n, chars.valid, !number.ready, "ready while emitting")
	`ASSERT_NEXT(a_start, clk, arst_n, in_fire, state_q != u2a_pkg::IDLE, "accept left idle")
	`ASSERT_NEXT(a_finish, clk, arst_n, out_fire && chars.last, state_q == u2a_pkg::IDLE, "no idle")
	`ASSERT_SAME(a_count, clk, arst_n, state_q == u2a_pkg::SPLIT, cnt_q < CNT_W'(DEPTH), "digit store overrun")

endmodule
